@@ rtl/core/tdet_pkg.sv @@
// tdet_pkg: shared types, codes, widths and the saturating-add helper function of the tilt detector
// used by every module under rtl/core
// no dependencies
package tdet_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int SUM_W = 32;
	localparam int ACC_W = 16;
	localparam int TIME_W = 64;
	localparam int BT_W = 32;
	localparam int THR_W = 31;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W = 2 * ACC_W;
	localparam int DOT_W = PROD_W + 2;
	localparam int DIV_STEPS = SUM_W;
	localparam int MUL_STEPS = ACC_W;
	localparam int STEP_W = $clog2(DIV_STEPS);

	localparam logic [BT_W-1:0] BATCH_TIME_RST = BT_W'(2000000000);
	localparam logic [THR_W-1:0] ANGLE_THRESH_RST = THR_W'(82646034);

	localparam logic [1:0] MODE_DISABLED = 2'd0;
	localparam logic [1:0] MODE_AWAIT_MOTION = 2'd1;
	localparam logic [1:0] MODE_AWAIT_TILT = 2'd2;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_ANY_MOTION = 2'd1;
	localparam logic [1:0] KIND_NO_MOTION = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_TIME = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_THRESH = CFG_IDX_W'(2);

	// sequencing strobes from the controller to a serial unit
	typedef struct packed {
		logic load;
		logic run;
		logic last;
	} tdet_seq_t;

	// saturating add of one sample to a batch sum
	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic signed [SUM_W:0] s;
		logic signed [SUM_W-1:0] r;
		s = {a[SUM_W-1], a} + {{(SUM_W + 1 - ACC_W){b[ACC_W-1]}}, b};
		if (s[SUM_W] != s[SUM_W-1]) begin
			r = s[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
		end else begin
			r = s[SUM_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/tilt_detector.sv @@
// Tilt detector: takes one word at a time over a valid/stall channel and returns one result word
// per input. An event passes S_UPD and S_DONE, a sample that leaves its batch open S_UPD, S_CHK and
// S_DONE, one that closes the first batch S_UPD, S_CHK, S_DIV, S_REF and S_DONE, and one that closes
// a later batch also S_MUL, S_DOT and S_CMP after S_REF. Closing uses the three-lane bit-serial
// divider (one quotient bit per cycle) and multiplier, which form the means and the products of the
// dot product. A finished result waits in the output register while the next word is taken in.
// Configuration writes are taken at any time and should be made while no word is in flight.
module tilt_detector import tdet_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              kind,
	input  logic [TIME_W-1:0]       timestamp_ns,
	input  logic signed [ACC_W-1:0] accel_x,
	input  logic signed [ACC_W-1:0] accel_y,
	input  logic signed [ACC_W-1:0] accel_z,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    tilt,
	output logic                    batch_closed,
	output logic [1:0]              mode
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_UPD   = 10'b00_0000_0010,
		S_CHK   = 10'b00_0000_0100,
		S_DIV   = 10'b00_0000_1000,
		S_REF   = 10'b00_0001_0000,
		S_MUL   = 10'b00_0010_0000,
		S_DOT   = 10'b00_0100_0000,
		S_CMP   = 10'b00_1000_0000,
		S_DONE  = 10'b01_0000_0000,
		S_SPARE = 10'b10_0000_0000
	} state_t;

	state_t                  state_q;
	logic [STEP_W-1:0]       step_q;
	logic [1:0]              mode_q;
	logic [BT_W-1:0]         batch_time_q;
	logic [THR_W-1:0]        thresh_q;
	logic                    open_q;
	logic [TIME_W-1:0]       start_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [ACC_W-1:0] ref_q [3];
	logic                    ref_valid_q;

	logic [1:0]              kind_q;
	logic [TIME_W-1:0]       ts_q;
	logic signed [ACC_W-1:0] acc_in_q [3];
	logic [TIME_W-1:0]       elapsed_q;
	logic signed [DOT_W-1:0] dot01_q;
	logic                    res_tilt_q;
	logic                    res_closed_q;

	logic                    out_valid_q;
	logic                    tilt_q;
	logic                    closed_q;
	logic [1:0]              out_mode_q;

	tdet_seq_t               div_seq;
	tdet_seq_t               mul_seq;
	logic signed [ACC_W-1:0] mean [3];
	logic signed [PROD_W-1:0] prod [3];

	logic                    accept;
	logic                    out_free;
	logic                    close;
	logic [TIME_W-1:0]       start_eff;
	logic signed [DOT_W-1:0] dot;
	logic                    below;

	assign accept = in_valid && !in_stall;
	assign in_stall = !arst_n || (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign start_eff = open_q ? start_q : ts_q;
	assign close = (elapsed_q[TIME_W-1:BT_W] != '0) || (elapsed_q[BT_W-1:0] > batch_time_q)
		|| (count_q == COUNT_MAX);
	assign dot = dot01_q + DOT_W'(prod[2]);
	assign below = dot < $signed({{(DOT_W - THR_W){1'b0}}, thresh_q});

	always_comb begin
		div_seq = '0;
		mul_seq = '0;
		div_seq.load = (state_q == S_CHK) && close;
		div_seq.run = state_q == S_DIV;
		mul_seq.load = (state_q == S_REF) && ref_valid_q;
		mul_seq.run = state_q == S_MUL;
		mul_seq.last = (state_q == S_MUL) && (step_q == STEP_W'(MUL_STEPS - 1));
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		tdet_div #(.COUNT_BITS(COUNT_BITS)) u_div (
			.clk   (clk),
			.seq   (div_seq),
			.sum   (sum_q[i]),
			.count (count_q),
			.mean  (mean[i])
		);

		tdet_mul u_mul (
			.clk  (clk),
			.seq  (mul_seq),
			.a    (mean[i]),
			.b    (ref_q[i]),
			.prod (prod[i])
		);
	end

	// captured word and datapath scratch, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			ts_q <= timestamp_ns;
			acc_in_q[0] <= accel_x;
			acc_in_q[1] <= accel_y;
			acc_in_q[2] <= accel_z;
		end
		if (state_q == S_UPD) begin
			elapsed_q <= ts_q - start_eff;
		end
		if (state_q == S_DOT) begin
			dot01_q <= DOT_W'(prod[0]) + DOT_W'(prod[1]);
		end
		if (((state_q == S_REF) && !ref_valid_q) || ((state_q == S_CMP) && below)) begin
			for (int i = 0; i < 3; i++) begin
				ref_q[i] <= mean[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			mode_q <= MODE_DISABLED;
			batch_time_q <= BATCH_TIME_RST;
			thresh_q <= ANGLE_THRESH_RST;
			open_q <= 1'b0;
			start_q <= '0;
			count_q <= '0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
			end
			ref_valid_q <= 1'b0;
			res_tilt_q <= 1'b0;
			res_closed_q <= 1'b0;
			out_valid_q <= 1'b0;
			tilt_q <= 1'b0;
			closed_q <= 1'b0;
			out_mode_q <= MODE_DISABLED;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					res_tilt_q <= 1'b0;
					res_closed_q <= 1'b0;
					if ((kind_q == KIND_SAMPLE) && (mode_q == MODE_AWAIT_TILT)) begin
						open_q <= 1'b1;
						start_q <= start_eff;
						for (int i = 0; i < 3; i++) begin
							sum_q[i] <= sat_add(sum_q[i], acc_in_q[i]);
						end
						if (count_q != COUNT_MAX) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= S_CHK;
					end else begin
						state_q <= S_DONE;
						if ((kind_q == KIND_ANY_MOTION) && (mode_q == MODE_AWAIT_MOTION)) begin
							mode_q <= MODE_AWAIT_TILT;
						end else if ((kind_q == KIND_NO_MOTION)
							&& (mode_q == MODE_AWAIT_TILT)) begin
							mode_q <= MODE_AWAIT_MOTION;
						end
					end
				end
				S_CHK: begin
					if (close) begin
						// the dividers have taken the sums, so the batch restarts now
						open_q <= 1'b0;
						start_q <= '0;
						count_q <= '0;
						for (int i = 0; i < 3; i++) begin
							sum_q[i] <= '0;
						end
						res_closed_q <= 1'b1;
						step_q <= '0;
						state_q <= S_DIV;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= S_REF;
					end
				end
				S_REF: begin
					step_q <= '0;
					if (ref_valid_q) begin
						state_q <= S_MUL;
					end else begin
						// first batch only latches the reference
						ref_valid_q <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(MUL_STEPS - 1)) begin
						state_q <= S_DOT;
					end
				end
				S_DOT: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					res_tilt_q <= below;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						tilt_q <= res_tilt_q;
						closed_q <= res_closed_q;
						out_mode_q <= mode_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ENABLE: mode_q <= cfg_data[0] ? MODE_AWAIT_MOTION : MODE_DISABLED;
					REG_BATCH_TIME: batch_time_q <= cfg_data[BT_W-1:0];
					REG_ANGLE_THRESH: thresh_q <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign tilt = tilt_q;
	assign batch_closed = closed_q;
	assign mode = out_mode_q;

endmodule

@@ rtl/core/tdet_div.sv @@
// tdet_div: one lane of the bit-serial restoring divider, batch sum over sample count
// truncates toward zero; one quotient bit per cycle
// depends on tdet_pkg
module tdet_div import tdet_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  tdet_seq_t               seq,
	input  logic signed [SUM_W-1:0] sum,
	input  logic [COUNT_BITS-1:0]   count,
	output logic signed [ACC_W-1:0] mean
);

	logic [SUM_W-1:0]      dvd_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] dvs_q;
	logic                  neg_q;
	logic [COUNT_BITS:0]   trial;
	logic                  ge;
	logic [COUNT_BITS:0]   diff;

	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign ge = trial >= {1'b0, dvs_q};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (seq.load) begin
			neg_q <= sum[SUM_W-1];
			dvd_q <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
			rem_q <= '0;
			dvs_q <= count;
		end else if (seq.run) begin
			// remainder stays below the divisor, so the top bit of the difference is zero
			rem_q <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
		end
	end

	// the mean of saturated 16-bit samples always fits 16 bits
	assign mean = neg_q ? ACC_W'(-dvd_q[ACC_W-1:0]) : dvd_q[ACC_W-1:0];

endmodule

@@ rtl/core/tdet_mul.sv @@
// tdet_mul: one lane of the bit-serial signed multiplier, mean times reference
// shift-add over the multiplier bits, the sign bit subtracted on the last step
// depends on tdet_pkg
module tdet_mul import tdet_pkg::*; (
	input  logic                     clk,
	input  tdet_seq_t                seq,
	input  logic signed [ACC_W-1:0]  a,
	input  logic signed [ACC_W-1:0]  b,
	output logic signed [PROD_W-1:0] prod
);

	logic [ACC_W-1:0]         mplr_q;
	logic signed [PROD_W-1:0] mcand_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] addend;

	always_comb begin
		if (!mplr_q[0]) begin
			addend = '0;
		end else if (seq.last) begin
			addend = -mcand_q;
		end else begin
			addend = mcand_q;
		end
	end

	always_ff @(posedge clk) begin
		if (seq.load) begin
			mplr_q <= a;
			mcand_q <= PROD_W'(b);
			acc_q <= '0;
		end else if (seq.run) begin
			acc_q <= acc_q + addend;
			mcand_q <= mcand_q <<< 1;
			mplr_q <= mplr_q >> 1;
		end
	end

	assign prod = acc_q;

endmodule

@@ rtl/core/tdet_checker.sv @@
// tdet_checker: port-level assertions for the tilt detector, bound to the top level
// depends on tdet_pkg and tilt_detector
module tdet_checker import tdet_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic [1:0]              kind,
	input logic [TIME_W-1:0]       timestamp_ns,
	input logic signed [ACC_W-1:0] accel_x,
	input logic signed [ACC_W-1:0] accel_y,
	input logic signed [ACC_W-1:0] accel_z,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic                    tilt,
	input logic                    batch_closed,
	input logic [1:0]              mode
);

	// one word in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is still in flight");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(kind) && $stable(timestamp_ns)
			&& $stable(accel_x) && $stable(accel_y) && $stable(accel_z))
		else $error("stalled input word changed");

	a_tilt_needs_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tilt |-> batch_closed)
		else $error("tilt flagged without a closed batch");

	// only a sample in awaiting tilt can close a batch, and it leaves the mode alone
	a_close_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && batch_closed |-> mode == MODE_AWAIT_TILT)
		else $error("batch closed outside awaiting tilt");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tilt) && $stable(batch_closed)
			&& $stable(mode))
		else $error("stalled result word changed");

endmodule

bind tilt_detector tdet_checker u_tdet_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// tb: self-checking testbench of tilt_detector, with a tracking model of mode, batch and tilt
// depends on rtl/core/tdet_pkg.sv and rtl/core/tilt_detector.sv

typedef struct packed {
	logic       tilt;
	logic       closed;
	logic [1:0] mode;
} outcome_t;

// tracks mode, batch sums and reference vector, and queues the outcome of each word
class tilt_tracker;
	logic [1:0]  mode_now;
	logic [31:0] batch_len;
	logic [30:0] thresh;
	bit          batch_running;
	logic [63:0] batch_t0;
	longint      n_samples;
	longint      sums[3];
	longint      ref_vec[3];
	bit          ref_set;
	int          count_top;
	outcome_t    outcome_q[$];
	int          words;
	int          results;
	int          closes;
	int          tilts;
	int          bad;

	function new();
		mode_now = tdet_pkg::MODE_DISABLED;
		batch_len = tdet_pkg::BATCH_TIME_RST;
		thresh = tdet_pkg::ANGLE_THRESH_RST;
		batch_running = 0;
		batch_t0 = '0;
		n_samples = 0;
		ref_set = 0;
		for (int i = 0; i < 3; i++) begin
			sums[i] = 0;
			ref_vec[i] = 0;
		end
		count_top = (1 << tdet_pkg::COUNT_BITS_DEF) - 1;
		words = 0;
		results = 0;
		closes = 0;
		tilts = 0;
		bad = 0;
	endfunction

	// enable only moves the mode, batch and reference are kept
	function void write_reg(logic [tdet_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		case (idx)
		tdet_pkg::REG_ENABLE: begin
			mode_now = data[0] ? tdet_pkg::MODE_AWAIT_MOTION : tdet_pkg::MODE_DISABLED;
		end
		tdet_pkg::REG_BATCH_TIME: batch_len = data;
		tdet_pkg::REG_ANGLE_THRESH: thresh = data[30:0];
		default: ;
		endcase
	endfunction

	// returns 1 when the word changed anything
	function bit take_word(logic [1:0] k, logic [63:0] ts, logic signed [15:0] ax,
			logic signed [15:0] ay, logic signed [15:0] az);
		outcome_t    o;
		logic [63:0] elapsed;
		longint      acc[3];
		longint      mean[3];
		longint      dot;
		longint      s;
		bit          live;
		o = '0;
		live = 0;
		case (k)
		tdet_pkg::KIND_SAMPLE: begin
			if (mode_now == tdet_pkg::MODE_AWAIT_TILT) begin
				live = 1;
				if (!batch_running) begin
					batch_running = 1;
					batch_t0 = ts;
				end
				acc[0] = longint'(ax);
				acc[1] = longint'(ay);
				acc[2] = longint'(az);
				for (int i = 0; i < 3; i++) begin
					s = sums[i] + acc[i];
					if (s > 64'sd2147483647)
						s = 64'sd2147483647;
					else if (s < -64'sd2147483648)
						s = -64'sd2147483648;
					sums[i] = s;
				end
				if (n_samples < count_top)
					n_samples++;
				// elapsed time wraps modulo 2^64
				elapsed = ts - batch_t0;
				if (elapsed > 64'(batch_len) || n_samples >= count_top) begin
					o.closed = 1'b1;
					closes++;
					for (int i = 0; i < 3; i++)
						mean[i] = sums[i] / n_samples;
					if (ref_set) begin
						dot = mean[0] * ref_vec[0] + mean[1] * ref_vec[1] + mean[2] * ref_vec[2];
						if (dot < longint'(thresh)) begin
							o.tilt = 1'b1;
							tilts++;
							ref_vec = mean;
						end
					end else begin
						ref_set = 1;
						ref_vec = mean;
					end
					batch_running = 0;
					batch_t0 = '0;
					n_samples = 0;
					for (int i = 0; i < 3; i++)
						sums[i] = 0;
				end
			end
		end
		tdet_pkg::KIND_ANY_MOTION: begin
			if (mode_now == tdet_pkg::MODE_AWAIT_MOTION) begin
				mode_now = tdet_pkg::MODE_AWAIT_TILT;
				live = 1;
			end
		end
		tdet_pkg::KIND_NO_MOTION: begin
			if (mode_now == tdet_pkg::MODE_AWAIT_TILT) begin
				mode_now = tdet_pkg::MODE_AWAIT_MOTION;
				live = 1;
			end
		end
		default: ;
		endcase
		o.mode = mode_now;
		outcome_q.push_back(o);
		words++;
		return live;
	endfunction

	function void match_outcome(logic t, logic c, logic [1:0] m);
		outcome_t want;
		results++;
		if (outcome_q.size() == 0) begin
			bad++;
			if (bad <= 10)
				$display("unexpected result word: tilt %0d batch_closed %0d mode %0d", t, c, m);
			return;
		end
		want = outcome_q.pop_front();
		if (t !== want.tilt || c !== want.closed || m !== want.mode) begin
			bad++;
			if (bad <= 10)
				$display("result %0d: expected tilt %0d batch_closed %0d mode %0d, got %0d %0d %0d",
					results, want.tilt, want.closed, want.mode, t, c, m);
		end
	endfunction
endclass

module tb;
	import tdet_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 7;
	localparam int LIMIT_CYCLES = 2500000;
	localparam int DRAIN_GAP = 60;
	localparam int LONG_HOLD = 400;
	localparam int PHASE_WORDS = 170;
	localparam int N_PHASES = 6;
	localparam int G_Q10 = 10045;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
	localparam logic [1:0] KIND_SPARE = 2'd3;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              kind;
	logic [TIME_W-1:0]       timestamp_ns;
	logic signed [ACC_W-1:0] accel_x;
	logic signed [ACC_W-1:0] accel_y;
	logic signed [ACC_W-1:0] accel_z;
	logic                    out_valid;
	logic                    out_stall;
	logic                    tilt;
	logic                    batch_closed;
	logic [1:0]              mode;

	tilt_tracker trk = new();
	bit          hold_ask;
	int          burst_left;
	int          live_words;
	int unsigned cycles;

	tilt_detector uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.timestamp_ns(timestamp_ns),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tilt(tilt),
		.batch_closed(batch_closed),
		.mode(mode)
	);

	always begin
		clk = 1'b0;
		#(HALF_PERIOD);
		clk = 1'b1;
		#(HALF_PERIOD);
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_word(input logic [1:0] k, input logic [63:0] ts,
			input logic signed [15:0] ax, input logic signed [15:0] ay,
			input logic signed [15:0] az);
		int gap;
		in_valid <= 1'b1;
		kind <= k;
		timestamp_ns <= ts;
		accel_x <= ax;
		accel_y <= ay;
		accel_z <= az;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (trk.take_word(k, ts, ax, ay, az))
			live_words++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(8);
			gap = ($urandom_range(4) == 0) ? $urandom_range(60, 8) : $urandom_range(5, 1);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_event(input logic [1:0] k);
		send_word(k, {$urandom, $urandom}, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// write strobe high for one cycle, then low again before the next write
	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		trk.write_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (trk.outcome_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// one batch around a gravity direction, with motion events as needed, or a single word of noise
	task automatic random_traffic();
		int                 n;
		int                 orient;
		int                 bx;
		int                 by;
		int                 bz;
		logic [63:0]        t0;
		logic [63:0]        pace;
		logic [63:0]        ts;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		if ($urandom_range(9) < 2) begin
			send_word(2'($urandom_range(3)), {$urandom, $urandom}, 16'($urandom),
				16'($urandom), 16'($urandom));
		end else begin
			if (trk.mode_now != MODE_AWAIT_TILT)
				send_event(KIND_ANY_MOTION);
			n = $urandom_range(6, 2);
			orient = $urandom_range(5);
			case (orient)
			0: begin bx = 0; by = 0; bz = G_Q10; end
			1: begin bx = 0; by = 0; bz = -G_Q10; end
			2: begin bx = G_Q10; by = 0; bz = 0; end
			3: begin bx = 0; by = G_Q10; bz = 0; end
			4: begin bx = 7100; by = 0; bz = 7100; end
			default: begin bx = 9439; by = 0; bz = 3436; end
			endcase
			t0 = trk.batch_running ? trk.batch_t0 : {$urandom, $urandom};
			pace = 64'(trk.batch_len) / n;
			for (int i = 0; i < n; i++) begin
				// only the last word of the batch runs past the batch time
				if (i == n - 1)
					ts = t0 + 64'(trk.batch_len) + 64'($urandom_range(4, 1));
				else
					ts = t0 + pace * i;
				ax = 16'(bx + int'($urandom_range(400)) - 200);
				ay = 16'(by + int'($urandom_range(400)) - 200);
				az = 16'(bz + int'($urandom_range(400)) - 200);
				send_word(KIND_SAMPLE, ts, ax, ay, az);
			end
			if ($urandom_range(15) == 0)
				send_event(KIND_NO_MOTION);
		end
	endtask

	// receiver: quiet stretches, random stalls, solid stalls, and one long hold-off on request
	initial begin
		int hold_left;
		int pat_left;
		int pat_kind;
		hold_left = 0;
		pat_left = 0;
		pat_kind = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_ask) begin
				hold_ask = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (pat_left == 0) begin
					pat_kind = $urandom_range(2);
					pat_left = (pat_kind == 2) ? $urandom_range(12, 1) : $urandom_range(50, 10);
				end
				pat_left--;
				if (pat_kind == 0)
					out_stall <= 1'b0;
				else if (pat_kind == 1)
					out_stall <= ($urandom_range(1) == 1);
				else
					out_stall <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			trk.match_outcome(tilt, batch_closed, mode);
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		logic [31:0] lens[N_PHASES];
		logic [30:0] threshes[N_PHASES];
		int          phase_end;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_SAMPLE;
		timestamp_ns = '0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		hold_ask = 0;
		burst_left = 0;
		live_words = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// disabled: everything ignored
		send_word(KIND_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 16'sh7FFF, -16'sh8000, 16'sh0000);
		send_event(KIND_ANY_MOTION);
		send_event(KIND_NO_MOTION);
		send_event(KIND_SPARE);
		settle();
		write_cfg(REG_ENABLE, 32'hFFFF_FFFF);
		write_cfg(REG_SPARE, $urandom);
		// awaiting motion: samples and no-motion ignored
		send_word(KIND_SAMPLE, 64'd77, 16'sd100, 16'sd200, 16'sd300);
		send_event(KIND_NO_MOTION);
		send_event(KIND_SPARE);
		send_event(KIND_ANY_MOTION);
		send_event(KIND_ANY_MOTION);
		// first batch opens at time zero, equal elapsed time keeps it open
		send_word(KIND_SAMPLE, 64'd0, 16'sh7FFF, -16'sh8000, 16'sd0);
		send_word(KIND_SAMPLE, 64'd2000000000, -16'sh8000, 16'sh7FFF, -16'sd1);
		send_word(KIND_SAMPLE, 64'd2000000001, 16'sd0, 16'sd0, 16'(G_Q10));
		// time wraps forward, then runs backwards
		send_word(KIND_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 16'sd0, 16'sd0, 16'(G_Q10));
		send_word(KIND_SAMPLE, 64'd5, 16'sd0, 16'sd0, 16'(G_Q10));
		send_word(KIND_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFE, 16'sd0, 16'sd0, 16'(G_Q10));
		send_word(KIND_SAMPLE, 64'd100, 16'sd7100, 16'sd0, 16'sd7100);
		send_word(KIND_SAMPLE, 64'd2000000200, 16'sd7100, 16'sd0, 16'sd7100);
		send_event(KIND_NO_MOTION);
		send_word(KIND_SAMPLE, 64'd3000000000, 16'sd1, 16'sd2, 16'sd3);
		send_event(KIND_ANY_MOTION);
		settle();
		write_cfg(REG_ENABLE, 32'hFFFF_FFFE);
		send_word(KIND_SAMPLE, 64'd4000000000, 16'sd1, 16'sd2, 16'sd3);
		send_event(KIND_ANY_MOTION);

		lens = '{32'd1000, 32'd0, 32'hFFFF_FFFF, $urandom, 32'd2000000000,
			32'($urandom_range(5000))};
		threshes = '{ANGLE_THRESH_RST, 31'd0, 31'h7FFF_FFFF, 31'($urandom), 31'($urandom),
			31'd82646034};
		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			write_cfg(REG_ENABLE, {31'($urandom), 1'b1});
			write_cfg(REG_BATCH_TIME, lens[p]);
			write_cfg(REG_ANGLE_THRESH, {1'($urandom), threshes[p]});
			if (p == 2)
				hold_ask = 1'b1;
			phase_end = live_words + PHASE_WORDS;
			while (live_words < phase_end)
				random_traffic();
		end

		settle();
		repeat (DRAIN_GAP) @(negedge clk);
		$display("covered %0d words (%0d with effect), %0d results, %0d batch closes, %0d tilts",
			trk.words, live_words, trk.results, trk.closes, trk.tilts);
		$display("%0d setting phases incl. zero and full-scale batch time and threshold, %0d %s",
			N_PHASES, trk.bad, "mismatches");
		if (trk.bad == 0 && trk.outcome_q.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/tdet_pkg.sv
rtl/core/tdet_div.sv
rtl/core/tdet_mul.sv
rtl/core/tilt_detector.sv
rtl/core/tdet_checker.sv
dv/tb.sv
